FILE: sv/lhel_pkg.sv
// shared types and constants for the link header ethertype locator
// no dependencies; used by every module of the block
package lhel_pkg;

    localparam int POS_W  = 17;
    localparam int BASE_W = 16;
    localparam int ET_W   = 16;

    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

    localparam int MIN_MAC_HEADER = 24;
    localparam int MAX_MAC_HEADER = 36;

    // relative position of the last snap byte for the shortest and longest mac header
    localparam logic [POS_W-1:0] LLC_FIRST_REL = POS_W'(MIN_MAC_HEADER + 2);
    localparam logic [POS_W-1:0] LLC_LAST_REL  = POS_W'(MAX_MAC_HEADER + 2);

    localparam logic [POS_W-1:0] ETH_ET_OFS   = 17'd12;
    localparam logic [POS_W-1:0] SLL_ET_OFS   = 17'd14;
    localparam logic [POS_W-1:0] SNAP_TO_ET   = 17'd4;
    localparam logic [POS_W-1:0] VLAN_TAG_LEN = 17'd4;
    localparam logic [POS_W-1:0] RT_LEN_LO_POS = 17'd2;
    localparam logic [POS_W-1:0] RT_LEN_HI_POS = 17'd3;
    localparam logic [BASE_W-1:0] RT_LEN_MIN  = 16'd4;

    localparam logic [23:0]     SNAP_HDR = 24'hAAAA03;
    localparam logic [ET_W-1:0] ET_IPV4  = 16'h0800;
    localparam logic [ET_W-1:0] ET_IPV6  = 16'h86DD;
    localparam logic [ET_W-1:0] ET_VLAN  = 16'h8100;

    localparam logic [1:0] FT_MGMT = 2'd0;
    localparam logic [1:0] FT_CTRL = 2'd1;
    localparam logic [1:0] FT_DATA = 2'd2;
    localparam logic [1:0] FT_EXT  = 2'd3;

    localparam logic REG_LINK_KIND = 1'b0;

    typedef enum logic [1:0] {
        LINK_ETH,
        LINK_SLL,
        LINK_WLAN,
        LINK_RADIOTAP
    } link_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RTLEN,
        PH_FCTL,
        PH_LLC,
        PH_ETYPE,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_IP,
        ST_VLAN,
        ST_BAD_ETYPE,
        ST_SKIP,
        ST_BAD_FTYPE,
        ST_NO_LLC,
        ST_BAD_LINK,
        ST_TRUNC
    } status_t;

    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       first_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        logic [POS_W-1:0] ethertype_offset;
        status_t          parse_status;
        logic [ET_W-1:0]  found_ethertype;
    } result_t;

endpackage

FILE: sv/lhel_in_reg.sv
// input register for packet byte beats
// depends on lhel_pkg; advances whenever the result register has room
module lhel_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lhel_pkg::beat_t s_beat,
    input  logic            room,
    output logic            advance,
    output lhel_pkg::beat_t beat
);

    logic            valid_reg;
    logic            valid_next;
    lhel_pkg::beat_t beat_reg;

    assign advance  = valid_reg && room;
    assign s_tready = !valid_reg || room;
    assign beat     = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg <= s_beat;
        end
    end

endmodule

FILE: sv/lhel_parser.sv
// per-packet parse state and decision logic for one byte beat
// depends on lhel_pkg; produces at most one result per beat
module lhel_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lhel_pkg::link_kind_t link_kind,
    input  logic                 advance,
    input  lhel_pkg::beat_t      beat,
    output logic                 res_valid,
    output lhel_pkg::result_t    res
);

    lhel_pkg::phase_t                 phase_reg, phase_next;
    logic [lhel_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]                       rtlen_lo_reg, rtlen_lo_next;
    logic [lhel_pkg::BASE_W-1:0]      base_reg, base_next;
    logic [23:0]                      recent_reg, recent_next;
    logic [lhel_pkg::POS_W-1:0]       eoff_reg, eoff_next;

    logic                             live;
    logic [lhel_pkg::BASE_W-1:0]      rt_len;
    logic [lhel_pkg::POS_W-1:0]       rel;
    logic [lhel_pkg::ET_W-1:0]        et;
    logic [1:0]                       ftype;
    logic [3:0]                       fsub;

    assign rt_len = {beat.pkt_byte, rtlen_lo_reg};
    assign ftype  = beat.pkt_byte[3:2];
    assign fsub   = beat.pkt_byte[7:4];

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        rtlen_lo_next = rtlen_lo_reg;
        base_next     = base_reg;
        recent_next   = recent_reg;
        eoff_next     = eoff_reg;
        live          = 1'b1;
        res_valid     = 1'b0;
        res           = '{ethertype_offset: '0, parse_status: lhel_pkg::ST_TRUNC,
                          found_ethertype: '0};

        if (beat.first_byte)
        begin
            pos_next      = '0;
            rtlen_lo_next = '0;
            base_next     = '0;
            recent_next   = '0;
            eoff_next     = '0;
            unique case (link_kind)
                lhel_pkg::LINK_ETH:
                begin
                    eoff_next  = lhel_pkg::ETH_ET_OFS;
                    phase_next = lhel_pkg::PH_ETYPE;
                end
                lhel_pkg::LINK_SLL:
                begin
                    eoff_next  = lhel_pkg::SLL_ET_OFS;
                    phase_next = lhel_pkg::PH_ETYPE;
                end
                lhel_pkg::LINK_WLAN:
                begin
                    phase_next = lhel_pkg::PH_FCTL;
                end
                default:
                begin
                    phase_next = lhel_pkg::PH_RTLEN;
                end
            endcase
        end
        else if (phase_reg == lhel_pkg::PH_IDLE || phase_reg == lhel_pkg::PH_DONE)
        begin
            // byte outside a packet
            live = 1'b0;
            if (beat.last_byte)
            begin
                phase_next = lhel_pkg::PH_IDLE;
            end
        end
        else if (pos_reg != lhel_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end

        recent_next = {recent_next[15:0], beat.pkt_byte};
        rel = pos_next - lhel_pkg::POS_W'(base_next);
        et  = recent_next[15:0];

        if (live)
        begin
            case (phase_next)
                lhel_pkg::PH_RTLEN:
                begin
                    if (pos_next == lhel_pkg::RT_LEN_LO_POS)
                    begin
                        rtlen_lo_next = beat.pkt_byte;
                    end
                    else if (pos_next == lhel_pkg::RT_LEN_HI_POS)
                    begin
                        base_next = rt_len;
                        if (rt_len < lhel_pkg::RT_LEN_MIN)
                        begin
                            res_valid         = 1'b1;
                            res.parse_status  = lhel_pkg::ST_BAD_FTYPE;
                        end
                        else
                        begin
                            phase_next = lhel_pkg::PH_FCTL;
                        end
                    end
                end
                lhel_pkg::PH_FCTL:
                begin
                    if (pos_next == lhel_pkg::POS_W'(base_next))
                    begin
                        if (ftype == lhel_pkg::FT_MGMT || ftype == lhel_pkg::FT_CTRL)
                        begin
                            res_valid        = 1'b1;
                            res.parse_status = lhel_pkg::ST_SKIP;
                        end
                        else if (ftype == lhel_pkg::FT_EXT)
                        begin
                            res_valid        = 1'b1;
                            res.parse_status = lhel_pkg::ST_BAD_FTYPE;
                        end
                        else if (!fsub[2])
                        begin
                            // plain and qos data subtypes carry a payload
                            phase_next = lhel_pkg::PH_LLC;
                        end
                        else
                        begin
                            res_valid        = 1'b1;
                            res.parse_status = lhel_pkg::ST_SKIP;
                        end
                    end
                end
                lhel_pkg::PH_LLC:
                begin
                    if (rel >= lhel_pkg::LLC_FIRST_REL && recent_next == lhel_pkg::SNAP_HDR)
                    begin
                        eoff_next  = pos_next + lhel_pkg::SNAP_TO_ET;
                        phase_next = lhel_pkg::PH_ETYPE;
                    end
                    else if (rel >= lhel_pkg::LLC_LAST_REL)
                    begin
                        res_valid        = 1'b1;
                        res.parse_status = lhel_pkg::ST_NO_LLC;
                    end
                end
                lhel_pkg::PH_ETYPE:
                begin
                    if (pos_next == eoff_next + 1'b1)
                    begin
                        res_valid           = 1'b1;
                        res.found_ethertype = et;
                        if (et == lhel_pkg::ET_IPV4 || et == lhel_pkg::ET_IPV6)
                        begin
                            res.ethertype_offset = eoff_next;
                            res.parse_status     = lhel_pkg::ST_IP;
                        end
                        else if (et == lhel_pkg::ET_VLAN)
                        begin
                            res.ethertype_offset = eoff_next + lhel_pkg::VLAN_TAG_LEN;
                            res.parse_status     = lhel_pkg::ST_VLAN;
                        end
                        else
                        begin
                            res.parse_status = lhel_pkg::ST_BAD_ETYPE;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (res_valid)
            begin
                phase_next = lhel_pkg::PH_DONE;
            end

            if (beat.last_byte)
            begin
                // a decision on the last byte wins over truncation
                res_valid  = 1'b1;
                phase_next = lhel_pkg::PH_IDLE;
            end
        end
        else
        begin
            recent_next = recent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= lhel_pkg::PH_IDLE;
            pos_reg      <= '0;
            rtlen_lo_reg <= '0;
            base_reg     <= '0;
            recent_reg   <= '0;
            eoff_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            rtlen_lo_reg <= rtlen_lo_next;
            base_reg     <= base_next;
            recent_reg   <= recent_next;
            eoff_reg     <= eoff_next;
        end
    end

    a_offset_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.parse_status != lhel_pkg::ST_IP &&
         res.parse_status != lhel_pkg::ST_VLAN) |-> res.ethertype_offset == '0)
        else $error("nonzero offset with a failing status");

    a_no_result_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !beat.first_byte &&
         (phase_reg == lhel_pkg::PH_IDLE || phase_reg == lhel_pkg::PH_DONE)) |-> !res_valid)
        else $error("result for a byte outside a packet");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && beat.last_byte) |=> phase_reg == lhel_pkg::PH_IDLE)
        else $error("parser not idle after last byte");

    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !beat.first_byte) |=> pos_reg >= $past(pos_reg))
        else $error("byte position went backward within a packet");

endmodule

FILE: sv/lhel_out_reg.sv
// result register on the master side of the stream
// depends on lhel_pkg; frees its slot in the cycle the beat is taken
module lhel_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lhel_pkg::result_t res,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lhel_pkg::result_t m_res
);

    logic              valid_reg;
    logic              valid_next;
    lhel_pkg::result_t res_reg;

    assign room     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: sv/link_header_ethertype_locator.sv
// top level of the link header ethertype locator: apb link-kind register,
// input register, parser and result register; depends on lhel_pkg
//
//   channel   dir   payload                                      beat taken when
//   s_*       in    tdata[7:0] byte, tuser[0] first, tlast last   s_tvalid && s_tready
//   m_*       out   tdata offset/ethertype, tuser[2:0] status     m_tvalid && m_tready
//   apb       in    link_kind at byte address 0                   psel && penable && pwrite
//
// one byte beat per cycle sustained while m_tready keeps up; the beat that decides
// a result passes the input register, and the result the result register, before
// it shows on m_*. the only loop is the per-packet parse state, updated once per
// beat. reset clears all parse state and sets link_kind to ethernet. a stalled
// m_tready holds the result register and backs up combinationally to s_tready.
module link_header_ethertype_locator
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pkt_byte
    input  logic [0:0]  s_tuser,    // [0] first_byte
    input  logic        s_tlast,    // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [16:0] ethertype_offset, [32:17] found_ethertype
    output logic [2:0]  m_tuser,    // [2:0] parse_status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lhel_pkg::link_kind_t link_kind_reg;
    lhel_pkg::link_kind_t link_kind_next;
    lhel_pkg::beat_t      s_beat;
    lhel_pkg::beat_t      beat;
    lhel_pkg::result_t    res;
    lhel_pkg::result_t    m_res;
    logic                 room;
    logic                 advance;
    logic                 res_valid;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lhel_pkg::REG_LINK_KIND) ? {30'b0, link_kind_reg} : '0;

    always_comb
    begin
        link_kind_next = link_kind_reg;
        if (psel && penable && pwrite && pready && paddr[2] == lhel_pkg::REG_LINK_KIND)
        begin
            link_kind_next = lhel_pkg::link_kind_t'(pwdata[1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_kind_reg <= lhel_pkg::LINK_ETH;
        end
        else
        begin
            link_kind_reg <= link_kind_next;
        end
    end

    assign s_beat = '{pkt_byte: s_tdata, first_byte: s_tuser[0], last_byte: s_tlast};

    lhel_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_beat   (s_beat),
        .room     (room),
        .advance  (advance),
        .beat     (beat)
    );

    lhel_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .link_kind (link_kind_reg),
        .advance   (advance),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    lhel_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {7'b0, m_res.found_ethertype, m_res.ethertype_offset};
    assign m_tuser = m_res.parse_status;

endmodule

FILE: tb/sv/lhel_locate_checker.sv
`timescale 1ns / 1ps
// result checker for the link header ethertype locator: follows the byte stream and
// the link_kind writes, works out each packet's ethertype result and compares it with
// the result stream; depends on lhel_pkg
module lhel_locate_checker
    import lhel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pkt_byte
    input  logic [0:0]  s_tuser,    // [0] first_byte
    input  logic        s_tlast,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // [16:0] ethertype_offset, [32:17] found_ethertype
    input  logic [2:0]  m_tuser,    // [2:0] parse_status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,

    output int          errors,
    output int          pending
);

    localparam logic [2:0] LINK_KIND_ADDR = 3'(4 * REG_LINK_KIND);

    link_kind_t       link_kind;
    phase_t           phase;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] mac_base;
    logic [POS_W-1:0] et_ofs;
    logic [BASE_W-1:0] rt_len;
    logic [23:0]      recent;
    logic             sent;

    result_t          located_q[$];

    initial errors = 0;

    task automatic flag_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
        $display("mismatch in %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic decide(input logic [POS_W-1:0] ofs, input status_t st,
                          input logic [ET_W-1:0] et);
        result_t r;
        r.ethertype_offset = ofs;
        r.parse_status     = st;
        r.found_ethertype  = et;
        located_q.push_back(r);
        sent  = 1'b1;
        phase = PH_DONE;
    endtask

    task automatic locate_ethertype(input logic [7:0] b, input logic first, input logic last);
        logic [POS_W-1:0] rel;
        logic [1:0]       ftype;
        logic [3:0]       fsub;
        logic [ET_W-1:0]  et;
        if (first)
        begin
            pos      = '0;
            rt_len   = '0;
            mac_base = '0;
            recent   = '0;
            sent     = 1'b0;
            et_ofs   = '0;
            case (link_kind)
                LINK_ETH:
                begin
                    et_ofs = ETH_ET_OFS;
                    phase  = PH_ETYPE;
                end
                LINK_SLL:
                begin
                    et_ofs = SLL_ET_OFS;
                    phase  = PH_ETYPE;
                end
                LINK_WLAN: phase = PH_FCTL;
                default:   phase = PH_RTLEN;
            endcase
        end
        else if (phase == PH_IDLE || phase == PH_DONE)
        begin
            // stray beat outside a packet, a last beat only rearms
            if (last)
                phase = PH_IDLE;
            return;
        end
        else if (pos != POS_MAX)
        begin
            pos = pos + 1'b1;
        end
        recent = {recent[15:0], b};

        case (phase)
            PH_RTLEN:
            begin
                if (pos == RT_LEN_LO_POS)
                begin
                    rt_len = {8'h00, b};
                end
                else if (pos == RT_LEN_HI_POS)
                begin
                    rt_len[15:8] = b;
                    mac_base = {1'b0, rt_len};
                    if (rt_len < RT_LEN_MIN)
                        decide('0, ST_BAD_FTYPE, '0);
                    else
                        phase = PH_FCTL;
                end
            end
            PH_FCTL:
            begin
                if (pos == mac_base)
                begin
                    ftype = b[3:2];
                    fsub  = b[7:4];
                    if (ftype == FT_MGMT || ftype == FT_CTRL)
                        decide('0, ST_SKIP, '0);
                    else if (ftype == FT_EXT)
                        decide('0, ST_BAD_FTYPE, '0);
                    else if (fsub < 4'd4 || (fsub >= 4'd8 && fsub < 4'd12))
                        phase = PH_LLC;
                    else
                        decide('0, ST_SKIP, '0);
                end
            end
            PH_LLC:
            begin
                rel = pos - mac_base;
                if (rel >= LLC_FIRST_REL && recent == SNAP_HDR)
                begin
                    et_ofs = pos + SNAP_TO_ET;
                    phase  = PH_ETYPE;
                end
                else if (rel >= LLC_LAST_REL)
                begin
                    decide('0, ST_NO_LLC, '0);
                end
            end
            PH_ETYPE:
            begin
                if (pos == et_ofs + 1'b1)
                begin
                    et = recent[15:0];
                    if (et == ET_IPV4 || et == ET_IPV6)
                        decide(et_ofs, ST_IP, et);
                    else if (et == ET_VLAN)
                        decide(et_ofs + VLAN_TAG_LEN, ST_VLAN, et);
                    else
                        decide('0, ST_BAD_ETYPE, et);
                end
            end
            default: ;
        endcase

        // a decision on the last beat wins over truncation
        if (last)
        begin
            if (!sent)
                decide('0, ST_TRUNC, '0);
            phase = PH_IDLE;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (located_q.size() == 0)
        begin
            flag_mismatch("result with none due", m_tdata, '0);
            return;
        end
        want = located_q.pop_front();
        if (m_tdata[16:0] !== want.ethertype_offset)
            flag_mismatch("ethertype_offset", m_tdata[16:0], want.ethertype_offset);
        if (m_tuser !== want.parse_status)
            flag_mismatch("parse_status", m_tuser, want.parse_status);
        if (m_tdata[32:17] !== want.found_ethertype)
            flag_mismatch("found_ethertype", m_tdata[32:17], want.found_ethertype);
        if (m_tdata[39:33] !== '0)
            flag_mismatch("tdata padding", m_tdata[39:33], '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_kind = LINK_ETH;
            phase     = PH_IDLE;
            pos       = '0;
            mac_base  = '0;
            et_ofs    = '0;
            rt_len    = '0;
            recent    = '0;
            sent      = 1'b0;
            located_q.delete();
            pending   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (psel && penable && pwrite && pready && paddr == LINK_KIND_ADDR)
                link_kind = link_kind_t'(pwdata[1:0]);
            if (s_tvalid && s_tready)
                locate_ethertype(s_tdata, s_tuser[0], s_tlast);
            pending = located_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_link_header_ethertype_locator.sv
`timescale 1ns / 1ps
// testbench top for the link header ethertype locator: builds ethernet, cooked,
// 802.11 and radiotap packets, drives the byte stream and the apb port, gives the
// verdict; depends on lhel_pkg, the block and lhel_locate_checker
module tb_link_header_ethertype_locator;
    import lhel_pkg::*;

    localparam logic [2:0] LINK_KIND_ADDR = 3'(4 * REG_LINK_KIND);
    localparam int SEG_BYTES   = 40;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_left = 0;
    int          bytes_sent = 0;
    bit          hold_request = 1'b0;
    link_kind_t  cur_link;
    logic [7:0]  frame[$];

    link_header_ethertype_locator i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lhel_locate_checker u_locate_chk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #6ms;
        $display("status: fail");
        $finish;
    end

    // result side: random back-pressure, or a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = first;
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_frame(input int cut, input bit with_last);
        for (int i = 0; i < cut; i++)
            push_byte(frame[i], i == 0, with_last && i == cut - 1);
        bytes_sent += cut;
        frame.delete();
    endtask

    task automatic set_link(input link_kind_t k, input bit noisy);
        logic [31:0] value;
        s_tvalid = 1'b0;
        wait (pending == 0);
        // bytes that give no result may still be in flight
        repeat (4) @(negedge clk);
        value = noisy ? 32'($urandom) : 32'd0;
        value[1:0] = k;
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = LINK_KIND_ADDR;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        cur_link = k;
    endtask

    task automatic add_random(input int n);
        repeat (n) frame.push_back(8'($urandom));
    endtask

    task automatic wired(input int hdr, input logic [15:0] et, input int tail);
        add_random(hdr);
        frame.push_back(et[15:8]);
        frame.push_back(et[7:0]);
        add_random(tail);
    endtask

    task automatic rt_prefix(input logic [15:0] len);
        add_random(2);
        frame.push_back(len[7:0]);
        frame.push_back(len[15:8]);
        if (len > 16'd4)
            add_random(int'(len) - 4);
    endtask

    // frame control, filler up to the snap header, snap, oui, ethertype, payload
    task automatic wlan(input logic [7:0] fc, input int snap_at, input logic [15:0] et,
                        input int tail);
        frame.push_back(fc);
        add_random(snap_at - 1);
        frame.push_back(SNAP_HDR[23:16]);
        frame.push_back(SNAP_HDR[15:8]);
        frame.push_back(SNAP_HDR[7:0]);
        add_random(3);
        frame.push_back(et[15:8]);
        frame.push_back(et[7:0]);
        add_random(tail);
    endtask

    function automatic logic [15:0] pick_et();
        case ($urandom_range(9))
            0, 1, 2, 3: return ET_IPV4;
            4, 5:       return ET_IPV6;
            6, 7:       return ET_VLAN;
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic rand_wlan();
        int         sub;
        int         snap_at;
        int         roll;
        logic [7:0] fc;
        sub = $urandom_range(7);
        if (sub > 3)
            sub += 4;
        roll = $urandom_range(99);
        fc = (roll < 75) ? {4'(sub), FT_DATA, 2'($urandom)} : 8'($urandom);
        roll = $urandom_range(99);
        if (roll < 80)
            snap_at = $urandom_range(MIN_MAC_HEADER, MAX_MAC_HEADER);
        else if (roll < 90)
            snap_at = $urandom_range(MAX_MAC_HEADER + 1, MAX_MAC_HEADER + 4);
        else
            snap_at = $urandom_range(MIN_MAC_HEADER - 6, MIN_MAC_HEADER - 1);
        wlan(fc, snap_at, pick_et(), $urandom_range(12));
    endtask

    task automatic directed_for(input link_kind_t k);
        int h;
        h = (k == LINK_ETH) ? int'(ETH_ET_OFS) : int'(SLL_ET_OFS);
        case (k)
            LINK_ETH, LINK_SLL:
            begin
                // stray beats while idle, then a packet restarted before its end
                push_byte(8'hA5, 1'b0, 1'b0);
                push_byte(8'h5A, 1'b0, 1'b1);
                wired(h, ET_IPV4, 0);   send_frame(8, 1'b0);
                wired(h, ET_IPV4, 3);   send_frame(frame.size(), 1'b1);
                wired(h, ET_IPV6, 0);   send_frame(frame.size(), 1'b1);
                wired(h, ET_VLAN, 5);   send_frame(frame.size(), 1'b1);
                wired(h, 16'h0000, 1);  send_frame(frame.size(), 1'b1);
                wired(h, 16'hFFFF, 1);  send_frame(frame.size(), 1'b1);
                wired(h, ET_IPV4, 2);   send_frame(h + 1, 1'b1);
                add_random(1);          send_frame(1, 1'b1);
            end
            LINK_WLAN:
            begin
                wlan(8'h00, 24, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
                wlan(8'h04, 24, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
                wlan(8'h0C, 24, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
                wlan(8'h48, 24, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
                wlan(8'hC8, 24, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
                wlan(8'h08, 24, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
                wlan(8'h3B, 30, ET_IPV6, 0);   send_frame(frame.size(), 1'b1);
                wlan(8'h88, 36, ET_VLAN, 2);   send_frame(frame.size(), 1'b1);
                wlan(8'hBA, 33, 16'h88CC, 2);  send_frame(frame.size(), 1'b1);
                wlan(8'h08, 37, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
            end
            default:
            begin
                rt_prefix(16'd0);   wlan(8'h08, 24, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
                rt_prefix(16'd3);   wlan(8'h08, 24, ET_IPV4, 2);   send_frame(frame.size(), 1'b1);
                rt_prefix(16'd4);   wlan(8'h08, 24, ET_IPV6, 0);   send_frame(frame.size(), 1'b1);
                rt_prefix(16'd300); wlan(8'h98, 28, ET_VLAN, 1);   send_frame(frame.size(), 1'b1);
                rt_prefix(16'd4);   wlan(8'h08, 24, ET_IPV4, 2);   send_frame(2, 1'b1);
            end
        endcase
    endtask

    task automatic random_segment();
        int          seg_start;
        int          pkts;
        int          roll;
        logic [15:0] len;
        seg_start = bytes_sent;
        pkts = 0;
        while (bytes_sent - seg_start < SEG_BYTES || pkts < 1)
        begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom), 1'b0, $urandom_range(3) == 0);
            case (cur_link)
                LINK_ETH: wired(int'(ETH_ET_OFS), pick_et(), $urandom_range(12));
                LINK_SLL: wired(int'(SLL_ET_OFS), pick_et(), $urandom_range(12));
                LINK_WLAN: rand_wlan();
                default:
                begin
                    roll = $urandom_range(99);
                    if (roll < 85)
                        len = 16'($urandom_range(4, 40));
                    else if (roll < 95)
                        len = 16'($urandom_range(3));
                    else
                        len = 16'($urandom_range(41, 600));
                    rt_prefix(len);
                    rand_wlan();
                end
            endcase
            roll = $urandom_range(99);
            if (roll < 80)
                send_frame(frame.size(), 1'b1);
            else
                send_frame($urandom_range(1, frame.size()), roll < 92);
            pkts++;
        end
        // a stray last beat closes a packet left open
        push_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rst_n       = 1'b0;
        tx_idle_pct = 28;
        rx_idle_pct = 85;
        cur_link    = LINK_ETH;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < 4; k++)
        begin
            set_link(link_kind_t'(k), 1'b0);
            directed_for(link_kind_t'(k));
        end

        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 28 : (p == 1) ? 85 : 0;
            rx_idle_pct = (p == 0) ? 85 : (p == 1) ? 28 : 0;
            for (int j = 0; j < 4; j++)
            begin
                set_link(link_kind_t'((j + p) % 4), 1'b1);
                random_segment();
            end
        end

        // receiver holds off while short packets keep coming, input must back up
        set_link(LINK_ETH, 1'b0);
        hold_request = 1'b1;
        repeat (8)
        begin
            wired(int'(ETH_ET_OFS), ET_IPV4, 0);
            send_frame(frame.size(), 1'b1);
        end

        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
